>>> design/assert_macros.svh
// Shared assertion shorthands. Each one is clocked on clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cond_a implies cond_b in the same cycle.
`define CHK_SAME(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Checks that cond_a implies cond_b in the next cycle.
`define CHK_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

>>> design/pei_pkg.sv
// ----------------------------------------------------------------------------
// pei_pkg
// Types, constants and helpers for the particle integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int MAX_PARTICLES_DEF = 65536;
  localparam int ACC_W             = 48;

  localparam logic [15:0] TIME_STEP_RST   = 16'd1092;
  localparam logic [16:0] RESTITUTION_RST = 17'd32768;
  localparam logic [30:0] SPEED_LIMIT_RST = 31'd5242880;
  localparam logic signed [31:0] WALL_LEFT_RST   = 32'sd0;
  localparam logic signed [31:0] WALL_RIGHT_RST  = 32'sd52428800;
  localparam logic signed [31:0] WALL_BOTTOM_RST = 32'sd0;
  localparam logic signed [31:0] WALL_TOP_RST    = 32'sd39321600;

  localparam logic [30:0] OUT31_MAX = 31'h7FFF_FFFF;
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [2:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_RESTITUTION = 3'd1,
    CFG_SPEED_LIMIT = 3'd2,
    CFG_WALL_LEFT   = 3'd3,
    CFG_WALL_RIGHT  = 3'd4,
    CFG_WALL_BOTTOM = 3'd5,
    CFG_WALL_TOP    = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    DU_DIV,
    DU_SQRT
  } du_mode_t;

  typedef struct packed {
    logic     start;
    du_mode_t mode;
  } du_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } du_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_VX, ST_VY, ST_SQX, ST_SQY, ST_SQS, ST_ROOT,
    ST_LIMX, ST_DIVX, ST_WDIVX, ST_LIMY, ST_DIVY, ST_WDIVY,
    ST_PX, ST_PY, ST_STAT,
    ST_WL, ST_BL, ST_WR, ST_BR, ST_WB, ST_BB, ST_WT, ST_BT,
    ST_MS, ST_WMS, ST_MD, ST_WMD, ST_MP, ST_WMP, ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] s,
                                               input logic [ACC_W-1:0] v);
    logic [ACC_W:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[ACC_W] ? {ACC_W{1'b1}} : t[ACC_W-1:0];
  endfunction

endpackage

>>> design/pei_mul.sv
// ----------------------------------------------------------------------------
// pei_mul
// Shared 33 x 33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pei_mul
  import pei_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> design/pei_dsu.sv
// ----------------------------------------------------------------------------
// pei_dsu
// Iterative divide / square-root unit: one shift-subtract step per cycle.
// Divide needs dividend[63:32] < divisor and gives a 32-bit quotient.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pei_dsu
  import pei_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  du_cmd_t     cmd,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output du_stat_t    stat,
  output logic [31:0] result
);

  localparam int STEPS = 32;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [34:0]      rem;
  logic [63:0]      work;
  logic [31:0]      quot;
  logic [31:0]      den;
  du_mode_t         mode;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [34:0] trial;
  logic [34:0] sub;
  logic        ge;

  always_comb begin
    if (mode == DU_DIV) begin
      trial = {rem[33:0], work[63]};
      sub   = {3'b000, den};
    end else begin
      trial = {rem[32:0], work[63:62]};
      sub   = {1'b0, quot, 2'b01};
    end
    ge = (trial >= sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode <= cmd.mode;
      den  <= divisor;
      quot <= '0;
      if (cmd.mode == DU_DIV) begin
        rem  <= {3'b000, dividend[63:32]};
        work <= {dividend[31:0], 32'd0};
      end else begin
        rem  <= '0;
        work <= dividend;
      end
    end else if (busy) begin
      rem  <= ge ? (trial - sub) : trial;
      quot <= {quot[30:0], ge};
      work <= (mode == DU_DIV) ? {work[62:0], 1'b0} : {work[61:0], 2'b00};
    end
  end

  assign stat   = '{busy: busy, done: done};
  assign result = quot;

  `CHK_NEXT(a_start_busy, cmd.start, busy, "unit not busy after start")
  `CHK_SAME(a_done_idle, done, !busy, "unit busy while reporting done")

endmodule

>>> design/particle_euler_integrate_collide.sv
// ----------------------------------------------------------------------------
// particle_euler_integrate_collide
// Symplectic Euler step, speed limit, frame statistics and box collision.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one particle per transfer; output
//   channel out_valid/out_ready carries one result per particle.
//   Configuration is a plain write port (cfg_en, cfg_index, cfg_data); write
//   it only while the block is idle. Indexes past the register list are ignored.
// Sequencing:
//   One particle at a time; the time per particle is set mostly by the
//   shared divide/square-root unit, which does each square root and
//   divide. Each wall hit adds a bounce state. A particle over the speed
//   limit adds two divides and a second square root. The frame's last
//   particle adds up to three divides for the means.
//   The multiplier is shared too, with a registered product.
// Reset:
//   rst (synchronous) restores the configuration defaults, clears the frame
//   statistics and empties the output register.
// Stall:
//   A finished result waits in the output register; the next particle is
//   taken meanwhile, and its result holds in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module particle_euler_integrate_collide
  import pei_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic [30:0]        density,
  input  logic [30:0]        pressure,
  input  logic               frame_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic               stats_valid,
  output logic [30:0]        mean_speed,
  output logic [30:0]        mean_density,
  output logic [30:0]        mean_pressure,
  output logic [30:0]        peak_speed
);

  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0]       CNT_MAX = CW'(MAX_PARTICLES);
  localparam logic signed [65:0]  ONE     = 66'sd1 <<< FRAC_BITS;

  // configuration
  logic [15:0]        time_step;
  logic [16:0]        restitution;
  logic [30:0]        speed_limit;
  logic signed [31:0] wall_left, wall_right, wall_bottom, wall_top;

  // particle working set
  logic signed [31:0] px, py, vx, vy, fx, fy;
  logic [30:0]        dens, pres;
  logic               last;
  logic               limited;
  logic [31:0]        speed;
  logic [63:0]        sumsq;

  // frame statistics
  logic [ACC_W-1:0] speed_sum, density_sum, pressure_sum;
  logic [31:0]      speed_peak;
  logic [CW-1:0]    particle_count;
  logic [30:0]      mean_s, mean_d, mean_p;

  state_t state, state_next;

  // shared units
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  du_cmd_t            du_cmd;
  du_stat_t           du_stat;
  logic [63:0]        du_dividend;
  logic [31:0]        du_divisor;
  logic [31:0]        du_res;

  logic [31:0] abs_vx, abs_vy;
  logic        sat_s, sat_d, sat_p;
  logic        out_free;
  logic        frame_end;

  pei_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pei_dsu u_dsu (
    .clk      (clk),
    .rst      (rst),
    .cmd      (du_cmd),
    .dividend (du_dividend),
    .divisor  (du_divisor),
    .stat     (du_stat),
    .result   (du_res)
  );

  assign abs_vx   = vx[31] ? 32'(-vx) : vx;
  assign abs_vy   = vy[31] ? 32'(-vy) : vy;
  // a mean saturates when sum >= count * 2^31
  assign sat_s    = speed_sum    >= (ACC_W'(particle_count) << 31);
  assign sat_d    = density_sum  >= (ACC_W'(particle_count) << 31);
  assign sat_p    = pressure_sum >= (ACC_W'(particle_count) << 31);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign frame_end = (state == ST_OUT) && out_free && last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TIME_STEP_RST;
      restitution <= RESTITUTION_RST;
      speed_limit <= SPEED_LIMIT_RST;
      wall_left   <= WALL_LEFT_RST;
      wall_right  <= WALL_RIGHT_RST;
      wall_bottom <= WALL_BOTTOM_RST;
      wall_top    <= WALL_TOP_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_TIME_STEP:   time_step   <= cfg_data[15:0];
        CFG_RESTITUTION: restitution <= cfg_data[16:0];
        CFG_SPEED_LIMIT: speed_limit <= cfg_data[30:0];
        CFG_WALL_LEFT:   wall_left   <= cfg_data;
        CFG_WALL_RIGHT:  wall_right  <= cfg_data;
        CFG_WALL_BOTTOM: wall_bottom <= cfg_data;
        CFG_WALL_TOP:    wall_top    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and operand selection for the shared units
  always_comb begin
    state_next  = state;
    mul_a       = 33'(vx);
    mul_b       = $signed({16'd0, restitution});
    du_cmd      = '{start: 1'b0, mode: DU_DIV};
    du_dividend = prod[63:0];
    du_divisor  = speed;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_VX;
      end
      ST_VX: begin
        mul_a      = 33'(fx);
        mul_b      = $signed({17'd0, time_step});
        state_next = ST_VY;
      end
      ST_VY: begin
        mul_a      = 33'(fy);
        mul_b      = $signed({17'd0, time_step});
        state_next = ST_SQX;
      end
      ST_SQX: begin
        mul_a      = 33'(vx);
        mul_b      = 33'(vx);
        state_next = ST_SQY;
      end
      ST_SQY: begin
        mul_a      = 33'(vy);
        mul_b      = 33'(vy);
        state_next = ST_SQS;
      end
      ST_SQS: begin
        du_cmd      = '{start: 1'b1, mode: DU_SQRT};
        du_dividend = sumsq + prod[63:0];
        state_next  = ST_ROOT;
      end
      ST_ROOT: begin
        if (du_stat.done) begin
          if (!limited && (du_res > {1'b0, speed_limit})) state_next = ST_LIMX;
          else state_next = ST_PX;
        end
      end
      ST_LIMX: begin
        mul_a      = $signed({1'b0, abs_vx});
        mul_b      = $signed({2'b00, speed_limit});
        state_next = ST_DIVX;
      end
      ST_DIVX: begin
        du_cmd     = '{start: 1'b1, mode: DU_DIV};
        state_next = ST_WDIVX;
      end
      ST_WDIVX: begin
        if (du_stat.done) state_next = ST_LIMY;
      end
      ST_LIMY: begin
        mul_a      = $signed({1'b0, abs_vy});
        mul_b      = $signed({2'b00, speed_limit});
        state_next = ST_DIVY;
      end
      ST_DIVY: begin
        du_cmd     = '{start: 1'b1, mode: DU_DIV};
        state_next = ST_WDIVY;
      end
      ST_WDIVY: begin
        // recompute the speed from the limited components
        if (du_stat.done) state_next = ST_SQX;
      end
      ST_PX: begin
        mul_a      = 33'(vx);
        mul_b      = $signed({17'd0, time_step});
        state_next = ST_PY;
      end
      ST_PY: begin
        mul_a      = 33'(vy);
        mul_b      = $signed({17'd0, time_step});
        state_next = ST_STAT;
      end
      ST_STAT: state_next = ST_WL;
      ST_WL: begin
        state_next = (px <= wall_left) ? ST_BL : ST_WR;
      end
      ST_BL: state_next = ST_WR;
      ST_WR: begin
        state_next = (px >= wall_right) ? ST_BR : ST_WB;
      end
      ST_BR: state_next = ST_WB;
      ST_WB: begin
        mul_a      = 33'(vy);
        state_next = (py <= wall_bottom) ? ST_BB : ST_WT;
      end
      ST_BB: state_next = ST_WT;
      ST_WT: begin
        mul_a = 33'(vy);
        if (py >= wall_top) state_next = ST_BT;
        else state_next = last ? ST_MS : ST_OUT;
      end
      ST_BT: state_next = last ? ST_MS : ST_OUT;
      ST_MS: begin
        du_cmd      = '{start: !sat_s, mode: DU_DIV};
        du_dividend = 64'(speed_sum);
        du_divisor  = 32'(particle_count);
        state_next  = sat_s ? ST_MD : ST_WMS;
      end
      ST_WMS: begin
        if (du_stat.done) state_next = ST_MD;
      end
      ST_MD: begin
        du_cmd      = '{start: !sat_d, mode: DU_DIV};
        du_dividend = 64'(density_sum);
        du_divisor  = 32'(particle_count);
        state_next  = sat_d ? ST_MP : ST_WMD;
      end
      ST_WMD: begin
        if (du_stat.done) state_next = ST_MP;
      end
      ST_MP: begin
        du_cmd      = '{start: !sat_p, mode: DU_DIV};
        du_dividend = 64'(pressure_sum);
        du_divisor  = 32'(particle_count);
        state_next  = sat_p ? ST_OUT : ST_WMP;
      end
      ST_WMP: begin
        if (du_stat.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // particle datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          px      <= pos_x;
          py      <= pos_y;
          vx      <= vel_x;
          vy      <= vel_y;
          fx      <= force_x;
          fy      <= force_y;
          dens    <= density;
          pres    <= pressure;
          last    <= frame_last;
          limited <= 1'b0;
        end
      end
      ST_VY:  vx <= sat32(66'(vx) + (prod >>> FRAC_BITS));
      // on the second pass through the squares, hold the limited vy
      ST_SQX: begin
        if (!limited) vy <= sat32(66'(vy) + (prod >>> FRAC_BITS));
      end
      ST_SQY: sumsq <= prod[63:0];
      ST_ROOT: begin
        if (du_stat.done) begin
          speed <= du_res;
          if (!limited && (du_res > {1'b0, speed_limit})) limited <= 1'b1;
        end
      end
      ST_WDIVX: begin
        if (du_stat.done) vx <= vx[31] ? 32'(-du_res) : du_res;
      end
      ST_WDIVY: begin
        if (du_stat.done) vy <= vy[31] ? 32'(-du_res) : du_res;
      end
      ST_PY:   px <= sat32(66'(px) + (prod >>> FRAC_BITS));
      ST_STAT: py <= sat32(66'(py) + (prod >>> FRAC_BITS));
      ST_WL: begin
        if (px <= wall_left) px <= sat32(66'(wall_left) + ONE);
      end
      ST_BL: vx <= sat32((-prod) >>> FRAC_BITS);
      ST_WR: begin
        if (px >= wall_right) px <= sat32(66'(wall_right) - ONE);
      end
      ST_BR: vx <= sat32((-prod) >>> FRAC_BITS);
      ST_WB: begin
        if (py <= wall_bottom) py <= sat32(66'(wall_bottom) + ONE);
      end
      ST_BB: vy <= sat32((-prod) >>> FRAC_BITS);
      ST_WT: begin
        if (py >= wall_top) py <= sat32(66'(wall_top) - ONE);
      end
      ST_BT: vy <= sat32((-prod) >>> FRAC_BITS);
      ST_MS: begin
        if (sat_s) mean_s <= OUT31_MAX;
      end
      ST_WMS: begin
        if (du_stat.done) mean_s <= du_res[30:0];
      end
      ST_MD: begin
        if (sat_d) mean_d <= OUT31_MAX;
      end
      ST_WMD: begin
        if (du_stat.done) mean_d <= du_res[30:0];
      end
      ST_MP: begin
        if (sat_p) mean_p <= OUT31_MAX;
      end
      ST_WMP: begin
        if (du_stat.done) mean_p <= du_res[30:0];
      end
      default: ;
    endcase
  end

  // frame statistics: accumulate before the wall tests, clear on frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_sum      <= '0;
      density_sum    <= '0;
      pressure_sum   <= '0;
      speed_peak     <= '0;
      particle_count <= '0;
    end else if (state == ST_STAT) begin
      speed_sum    <= acc_add(speed_sum, ACC_W'(speed));
      density_sum  <= acc_add(density_sum, ACC_W'(dens));
      pressure_sum <= acc_add(pressure_sum, ACC_W'(pres));
      if (speed > speed_peak) speed_peak <= speed;
      if (particle_count < CNT_MAX) particle_count <= particle_count + 1'b1;
    end else if (frame_end) begin
      speed_sum      <= '0;
      density_sum    <= '0;
      pressure_sum   <= '0;
      speed_peak     <= '0;
      particle_count <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      new_pos_x     <= px;
      new_pos_y     <= py;
      new_vel_x     <= vx;
      new_vel_y     <= vy;
      stats_valid   <= last;
      mean_speed    <= last ? mean_s : '0;
      mean_density  <= last ? mean_d : '0;
      mean_pressure <= last ? mean_p : '0;
      peak_speed    <= !last ? '0 : (speed_peak[31] ? OUT31_MAX : speed_peak[30:0]);
    end
  end

  `CHK_SAME(a_idle_unit_free, in_ready, !du_stat.busy, "shared unit busy while idle")
  `CHK_SAME(a_count_bound, 1'b1, particle_count <= CNT_MAX, "particle count past limit")
  `CHK_NEXT(a_stats_clear, frame_end, particle_count == '0, "frame stats not cleared")

endmodule
